/* hdl/assert_macros.svh */
// Assertion helpers included by the detector core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define VDRD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vdrd assertion failed");

// Next-cycle implication, checked outside of reset.
`define VDRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vdrd assertion failed");

`endif

/* hdl/vdrd_pkg.sv */
package vdrd_pkg;

    // Field widths.
    localparam int COORD_BITS  = 12;
    localparam int SAMPLE_BITS = 16;
    localparam int LINE_BITS   = 10;
    localparam int EXT_BITS    = 8;
    localparam int GOOD_BITS   = EXT_BITS + 1;

    // Stream data widths, padded to whole bytes.
    localparam int S_FIELD_BITS = SAMPLE_BITS + COORD_BITS + LINE_BITS;
    localparam int M_FIELD_BITS = COORD_BITS + COORD_BITS + LINE_BITS;
    localparam int S_TDATA_W    = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((M_FIELD_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = COORD_BITS;

    // Active line windows: first line and one past the last line.
    localparam logic [LINE_BITS-1:0] PAL_FIRST_LINE  = LINE_BITS'(22);
    localparam logic [LINE_BITS-1:0] PAL_LINE_LIMIT  = LINE_BITS'(308);
    localparam logic [LINE_BITS-1:0] NTSC_FIRST_LINE = LINE_BITS'(20);
    localparam logic [LINE_BITS-1:0] NTSC_LINE_LIMIT = LINE_BITS'(259);
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX    = {SAMPLE_BITS{1'b1}};

    // Register reset values.
    localparam logic [EXT_BITS-1:0]   RST_POST_TRIGGER = EXT_BITS'(10);
    localparam logic [EXT_BITS-1:0]   RST_PRE_EXT      = EXT_BITS'(16);
    localparam logic [EXT_BITS-1:0]   RST_POST_EXT     = EXT_BITS'(10);
    localparam logic [COORD_BITS-1:0] RST_BURST_START  = COORD_BITS'(0);
    localparam logic [COORD_BITS-1:0] RST_ACTIVE_END   = COORD_BITS'(1023);

    // Register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_POST_TRIGGER = 3'd0,
        REG_PRE_EXT      = 3'd1,
        REG_POST_EXT     = 3'd2,
        REG_BURST_START  = 3'd3,
        REG_ACTIVE_END   = 3'd4,
        REG_SOURCE_PAL   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [EXT_BITS-1:0]   post_trigger_width;
        logic [EXT_BITS-1:0]   pre_extension;
        logic [EXT_BITS-1:0]   post_extension;
        logic [COORD_BITS-1:0] burst_start_x;
        logic [COORD_BITS-1:0] active_end_x;
        logic                  source_is_pal;
    } cfg_t;

    typedef struct packed {
        logic [LINE_BITS-1:0]   line_number;
        logic [COORD_BITS-1:0]  pixel_x;
        logic [SAMPLE_BITS-1:0] sample_value;
    } item_t;

    typedef struct packed {
        logic                  run_active;
        logic [GOOD_BITS-1:0]  good_count;
        logic [COORD_BITS-1:0] run_start_x;
    } run_state_t;

    typedef struct packed {
        logic [LINE_BITS-1:0]  dropout_line;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] start_x;
    } result_t;

endpackage

/* hdl/vdrd_step.sv */
// Per-sample run tracking: next run state and the closing result.
module vdrd_step (
    input  vdrd_pkg::cfg_t       cfg,
    input  vdrd_pkg::item_t      item,
    input  vdrd_pkg::run_state_t cur,
    output vdrd_pkg::run_state_t nxt,
    output logic                 emit,
    output vdrd_pkg::result_t    result
);

    localparam int CB = vdrd_pkg::COORD_BITS;
    localparam int GB = vdrd_pkg::GOOD_BITS;

    logic                   line_ok;
    logic                   x_ok;
    logic                   bad_raw;
    logic                   line_end;
    logic                   force_close;
    logic                   bad;
    logic [GB-1:0]          ptw_wide;
    logic [GB-1:0]          gc_base;
    logic [GB-1:0]          gc_inc;
    logic [CB-1:0]          pre_wide;
    logic [CB:0]            end_sum;
    logic [CB:0]            end_raw;

    // Line and position window.
    always_comb begin
        if (cfg.source_is_pal) begin
            line_ok = (item.line_number >= vdrd_pkg::PAL_FIRST_LINE) &&
                      (item.line_number <  vdrd_pkg::PAL_LINE_LIMIT);
        end else begin
            line_ok = (item.line_number >= vdrd_pkg::NTSC_FIRST_LINE) &&
                      (item.line_number <  vdrd_pkg::NTSC_LINE_LIMIT);
        end
        x_ok = (item.pixel_x >= cfg.burst_start_x) && (item.pixel_x <= cfg.active_end_x);
    end

    // Dropout test; near the line end a sample is treated as good and the
    // good counter is loaded so that an open run closes here.
    assign bad_raw     = (item.sample_value == '0) ||
                         (item.sample_value == vdrd_pkg::SAMPLE_MAX);
    assign line_end    = ({1'b0, item.pixel_x} + (CB+1)'(1)) >= {1'b0, cfg.active_end_x};
    assign force_close = line_end && (cur.run_active || bad_raw);
    assign bad         = bad_raw && !force_close;
    assign ptw_wide    = {1'b0, cfg.post_trigger_width};
    assign gc_base     = force_close ? (ptw_wide + GB'(1)) : cur.good_count;
    assign gc_inc      = gc_base + GB'(1);

    // Run state update.
    always_comb begin
        nxt  = cur;
        emit = 1'b0;
        if (line_ok && x_ok) begin
            if (bad) begin
                if (!cur.run_active) begin
                    nxt.run_active  = 1'b1;
                    nxt.run_start_x = item.pixel_x;
                end
                nxt.good_count = '0;
            end else if (!cur.run_active) begin
                nxt.good_count = gc_base;
            end else if (gc_inc > ptw_wide) begin
                nxt.run_active = 1'b0;
                nxt.good_count = '0;
                emit           = 1'b1;
            end else begin
                nxt.good_count = gc_inc;
            end
        end
    end

    // Extended start, clamped at zero.
    assign pre_wide = CB'(cfg.pre_extension);
    assign result.start_x = (cur.run_start_x >= pre_wide) ? (cur.run_start_x - pre_wide) : '0;

    // Extended end: closing pixel minus one plus the post extension,
    // clamped to zero and to the active end.
    assign end_sum = {1'b0, item.pixel_x} + (CB+1)'(cfg.post_extension);
    assign end_raw = (end_sum == '0) ? '0 : (end_sum - (CB+1)'(1));
    assign result.end_x = (end_raw >= {1'b0, cfg.active_end_x}) ? cfg.active_end_x
                                                                 : end_raw[CB-1:0];
    assign result.dropout_line = item.line_number;

endmodule

/* hdl/video_dropout_run_detector_core.sv */
// Channel  | Direction | Handshake              | Payload
// s_       | in        | s_tvalid / s_tready    | s_tdata: sample, pixel_x, line
// m_       | out       | m_tvalid / m_tready    | m_tdata: start_x, end_x, line
// cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One sample is taken per clock while the m_ side is not stalled. A request is
// held in the input register, and its result (if any) is loaded into the output
// register once that register is free, which raises m_tvalid. The run
// state is updated in that single step, which sets the one-per-clock rate.
// Reset (aresetn, synchronous) clears both stages and the run state and loads
// the register defaults. A stalled m_ side holds the result and, once the input
// register is full, drops s_tready; configuration writes are always taken.
`include "assert_macros.svh"

module video_dropout_run_detector_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [15:0] sample_value, [27:16] pixel_x, [37:28] line_number, rest zero
    input  logic [vdrd_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [11:0] start_x, [23:12] end_x, [33:24] dropout_line, rest zero
    output logic [vdrd_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [vdrd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [vdrd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    vdrd_pkg::cfg_t       cfg_reg;
    vdrd_pkg::item_t      item_reg;
    logic                 in_valid_reg;
    vdrd_pkg::run_state_t state_reg;
    vdrd_pkg::run_state_t state_next;
    vdrd_pkg::result_t    result_reg;
    vdrd_pkg::result_t    step_result;
    logic                 m_valid_reg;
    logic                 step_emit;
    logic                 out_free;
    logic                 consume;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.post_trigger_width <= vdrd_pkg::RST_POST_TRIGGER;
            cfg_reg.pre_extension      <= vdrd_pkg::RST_PRE_EXT;
            cfg_reg.post_extension     <= vdrd_pkg::RST_POST_EXT;
            cfg_reg.burst_start_x      <= vdrd_pkg::RST_BURST_START;
            cfg_reg.active_end_x       <= vdrd_pkg::RST_ACTIVE_END;
            cfg_reg.source_is_pal      <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                vdrd_pkg::REG_POST_TRIGGER:
                    cfg_reg.post_trigger_width <= cfg_data[vdrd_pkg::EXT_BITS-1:0];
                vdrd_pkg::REG_PRE_EXT:
                    cfg_reg.pre_extension <= cfg_data[vdrd_pkg::EXT_BITS-1:0];
                vdrd_pkg::REG_POST_EXT:
                    cfg_reg.post_extension <= cfg_data[vdrd_pkg::EXT_BITS-1:0];
                vdrd_pkg::REG_BURST_START:
                    cfg_reg.burst_start_x <= cfg_data[vdrd_pkg::COORD_BITS-1:0];
                vdrd_pkg::REG_ACTIVE_END:
                    cfg_reg.active_end_x <= cfg_data[vdrd_pkg::COORD_BITS-1:0];
                vdrd_pkg::REG_SOURCE_PAL:
                    cfg_reg.source_is_pal <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Flow control: the input register drains whenever the output is free.
    assign out_free = !m_valid_reg || m_tready;
    assign consume  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= vdrd_pkg::item_t'(s_tdata[vdrd_pkg::S_FIELD_BITS-1:0]);
        end
    end

    vdrd_step u_step (
        .cfg    (cfg_reg),
        .item   (item_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .emit   (step_emit),
        .result (step_result)
    );

    // Run state advances once per consumed request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (consume) begin
            state_reg <= state_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= consume && step_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && step_emit) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = vdrd_pkg::M_TDATA_W'(result_reg);

    // A result can only come from an open run, and closing it ends the run.
    `VDRD_ASSERT_NOW(a_emit_from_run, aclk, aresetn, consume && step_emit, state_reg.run_active)
    `VDRD_ASSERT_NEXT(a_emit_closes, aclk, aresetn, consume && step_emit, !state_reg.run_active)
    // The reported end never passes the active end.
    `VDRD_ASSERT_NOW(a_end_clamped, aclk, aresetn, m_valid_reg,
                     result_reg.end_x <= cfg_reg.active_end_x)

endmodule
